FILE: rtl/lfk_pkg.sv
package lfk_pkg;

  // Block sizes.
  localparam int NUM_LEGS  = 4;
  localparam int LEG_W     = 2;
  localparam int ANG_W     = 16;
  localparam int LEN_W     = 14;
  localparam int POS_W     = 16;
  localparam int OFS_W     = 48;
  localparam int CFG_IDX_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HIP      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_BASE = 8'd3;

  // CORDIC: angles in 2^-24 rad, vector in Q2.30.
  localparam int CORDIC_N = 24;
  localparam int CW       = 33;
  localparam int ZW       = 29;
  localparam int SH_W     = 5;

  localparam logic signed [ZW-1:0] ANG_PI      = 29'sd52707179;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 29'sd26353589;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 29'sd105414357;
  localparam logic signed [CW-1:0] CORDIC_K    = 33'sd652032874;

  // Square root: one result bit per cell.
  localparam int SQ_N     = 24;
  localparam int SQ_IN_W  = 2 * SQ_N;
  localparam int SQ_REM_W = SQ_N + 3;

  // Arctangent of 2^-i in 2^-24 rad.
  function automatic logic signed [ZW-1:0] atan_at(input logic [SH_W-1:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:    a = 29'sd13176795;
      5'd1:    a = 29'sd7778716;
      5'd2:    a = 29'sd4110060;
      5'd3:    a = 29'sd2086331;
      5'd4:    a = 29'sd1047214;
      5'd5:    a = 29'sd524117;
      5'd6:    a = 29'sd262123;
      5'd7:    a = 29'sd131069;
      5'd8:    a = 29'sd65536;
      5'd9:    a = 29'sd32768;
      5'd10:   a = 29'sd16384;
      5'd11:   a = 29'sd8192;
      5'd12:   a = 29'sd4096;
      5'd13:   a = 29'sd2048;
      5'd14:   a = 29'sd1024;
      5'd15:   a = 29'sd512;
      5'd16:   a = 29'sd256;
      5'd17:   a = 29'sd128;
      5'd18:   a = 29'sd64;
      5'd19:   a = 29'sd32;
      5'd20:   a = 29'sd16;
      5'd21:   a = 29'sd8;
      5'd22:   a = 29'sd4;
      5'd23:   a = 29'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic [LEG_W-1:0]        leg;
    logic signed [ANG_W-1:0] abduction_angle;
    logic signed [ANG_W-1:0] hip_angle;
    logic signed [ANG_W-1:0] knee_angle;
  } fk_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] foot_x;
    logic signed [POS_W-1:0] foot_y;
    logic signed [POS_W-1:0] foot_z;
    logic                    saturated;
  } fk_out_t;

  // One CORDIC lane between cells.
  typedef struct packed {
    logic                 neg;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // One square-root step between cells.
  typedef struct packed {
    logic [SQ_IN_W-1:0]  n;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_N-1:0]     root;
  } sqrt_t;

endpackage

FILE: rtl/lfk_cordic_cell.sv
module lfk_cordic_cell import lfk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SH_W-1:0]      shift_i,
  input  logic signed [ZW-1:0] atan_i,
  input  cord_t                cord_i,
  output cord_t                cord_o
);

  cord_t                cord_d, cord_q;
  logic signed [CW-1:0] x_sh, y_sh;

  // One micro-rotation, direction set by the sign of the residual angle.
  always_comb begin
    x_sh   = $signed(cord_i.x) >>> shift_i;
    y_sh   = $signed(cord_i.y) >>> shift_i;
    cord_d = cord_i;
    if (!cord_i.z[ZW-1]) begin
      cord_d.x = cord_i.x - y_sh;
      cord_d.y = cord_i.y + x_sh;
      cord_d.z = cord_i.z - atan_i;
    end else begin
      cord_d.x = cord_i.x + y_sh;
      cord_d.y = cord_i.y - x_sh;
      cord_d.z = cord_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

FILE: rtl/lfk_sqrt_cell.sv
module lfk_sqrt_cell import lfk_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  sqrt_t               sq_d, sq_q;
  logic [SQ_REM_W-1:0] rem_sh, trial;

  // Bring down the next two radicand bits and try a one in the root.
  always_comb begin
    rem_sh = {sq_i.rem[SQ_REM_W-3:0], sq_i.n[SQ_IN_W-1 -: 2]};
    trial  = SQ_REM_W'({sq_i.root, 2'b01});
    sq_d   = sq_i;
    sq_d.n = {sq_i.n[SQ_IN_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_d.rem  = rem_sh - trial;
      sq_d.root = {sq_i.root[SQ_N-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_sh;
      sq_d.root = {sq_i.root[SQ_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

FILE: rtl/leg_forward_kinematics.sv
// Throughput: one beat per cycle; the whole pipeline holds only while the output
// register is full and stalled.
// Depth is set by the 24-cell CORDIC chains and the 24-cell square-root chain.
// Reset clears all valid bits and sets every configuration register to zero.
module leg_forward_kinematics import lfk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fk_in_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fk_out_t              out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OFS_W-1:0]     cfg_data_i
);

  localparam int PRE_STG   = 1 + CORDIC_N + 1 + 3 + SQ_N + 4;
  localparam int KS_DLY    = 3 + SQ_N;
  localparam int KN_SH     = 11;
  localparam int SW_SH     = 10;
  localparam int UV_W      = 2 * LEN_W;
  localparam int SQS_W     = 2 * LEN_W + 1;
  localparam int PROD_W    = CW + UV_W + 1;
  localparam int L2_W      = 2 * LEN_W + 3;
  localparam int SQ_PRE_SH = SQ_IN_W - L2_W - 1;
  localparam int RND_SH    = 30;
  localparam int OUT_SH    = 38;
  localparam int X_SH      = 8;
  localparam int MUL1_W    = SQ_N + 1 + CW;
  localparam int XH_W      = SQ_N + 4;
  localparam int YH_W      = LEN_W + X_SH + 1;
  localparam int M2_W      = CW + XH_W;
  localparam int PT_W      = 20;
  localparam logic signed [PT_W:0] POS_MAX = (PT_W+1)'(2**(POS_W-1) - 1);
  localparam logic signed [PT_W:0] POS_MIN = -(PT_W+1)'(2**(POS_W-1));

  typedef struct packed {
    logic [LEG_W-1:0]     leg;
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] ss;
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] sa;
  } side_t;

  // Configuration registers.
  logic [LEN_W-1:0] hip_len_q, upper_len_q, lower_len_q;
  logic [OFS_W-1:0] ofs_q [NUM_LEGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hip_len_q   <= '0;
      upper_len_q <= '0;
      lower_len_q <= '0;
      for (int k = 0; k < NUM_LEGS; k++) begin
        ofs_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_HIP) begin
        hip_len_q <= cfg_data_i[LEN_W-1:0];
      end
      if (cfg_index_i == REG_UPPER) begin
        upper_len_q <= cfg_data_i[LEN_W-1:0];
      end
      if (cfg_index_i == REG_LOWER) begin
        lower_len_q <= cfg_data_i[LEN_W-1:0];
      end
      for (int k = 0; k < NUM_LEGS; k++) begin
        if (cfg_index_i == REG_OFS_BASE + CFG_IDX_W'(k)) begin
          ofs_q[k] <= cfg_data_i;
        end
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // Pipeline flow control: everything moves unless the output beat is held.
  logic               adv;
  logic               out_valid_q;
  fk_out_t            out_q;
  logic [PRE_STG-1:0] vld_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PRE_STG-2:0], in_valid_i};
      out_valid_q <= vld_q[PRE_STG-1];
    end
  end

  // Angle scaling, reduction to [-pi, pi] and fold to [-pi/2, pi/2].
  function automatic cord_t cord_start(input logic signed [ZW-1:0] a);
    logic signed [ZW-1:0] r;
    cord_t                c;
    r = a;
    if (a > ANG_PI) begin
      r = a - ANG_TWO_PI;
    end else if (a < -ANG_PI) begin
      r = a + ANG_TWO_PI;
    end
    c.neg = 1'b0;
    if (r > ANG_HALF_PI) begin
      r     = r - ANG_PI;
      c.neg = 1'b1;
    end else if (r < -ANG_HALF_PI) begin
      r     = r + ANG_PI;
      c.neg = 1'b1;
    end
    c.x = CORDIC_K;
    c.y = '0;
    c.z = r;
    return c;
  endfunction

  logic signed [ANG_W+1:0] sw_sum;
  logic signed [ZW-1:0]    kn_a, sw_a, ab_a;

  always_comb begin
    sw_sum = (ANG_W+2)'(in_data_i.hip_angle) + (ANG_W+2)'(in_data_i.hip_angle)
           + (ANG_W+2)'(in_data_i.knee_angle);
    kn_a   = ZW'(in_data_i.knee_angle) <<< KN_SH;
    ab_a   = ZW'(in_data_i.abduction_angle) <<< KN_SH;
    sw_a   = ZW'(sw_sum) <<< SW_SH;
  end

  cord_t            kn_r0_q, sw_r0_q, ab_r0_q;
  cord_t            kn_c [CORDIC_N+1];
  cord_t            sw_c [CORDIC_N+1];
  cord_t            ab_c [CORDIC_N+1];
  logic [LEG_W-1:0] leg_c_q [CORDIC_N+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kn_r0_q    <= cord_start(kn_a);
      sw_r0_q    <= cord_start(sw_a);
      ab_r0_q    <= cord_start(ab_a);
      leg_c_q[0] <= in_data_i.leg;
      for (int i = 0; i < CORDIC_N; i++) begin
        leg_c_q[i+1] <= leg_c_q[i];
      end
    end
  end

  assign kn_c[0] = kn_r0_q;
  assign sw_c[0] = sw_r0_q;
  assign ab_c[0] = ab_r0_q;

  // Three CORDIC chains side by side: knee, swing and abduction.
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    lfk_cordic_cell u_kn (
      .clk_i  (clk_i),
      .en_i   (adv),
      .shift_i(SH_W'(i)),
      .atan_i (atan_at(SH_W'(i))),
      .cord_i (kn_c[i]),
      .cord_o (kn_c[i+1])
    );
    lfk_cordic_cell u_sw (
      .clk_i  (clk_i),
      .en_i   (adv),
      .shift_i(SH_W'(i)),
      .atan_i (atan_at(SH_W'(i))),
      .cord_i (sw_c[i]),
      .cord_o (sw_c[i+1])
    );
    lfk_cordic_cell u_ab (
      .clk_i  (clk_i),
      .en_i   (adv),
      .shift_i(SH_W'(i)),
      .atan_i (atan_at(SH_W'(i))),
      .cord_i (ab_c[i]),
      .cord_o (ab_c[i+1])
    );
  end

  // Undo the fold: negate cosine and sine where the angle was shifted by pi.
  logic signed [CW-1:0] n_ck_q;
  side_t                n_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_ck_q       <= kn_c[CORDIC_N].neg ? -kn_c[CORDIC_N].x : kn_c[CORDIC_N].x;
      n_side_q.cs  <= sw_c[CORDIC_N].neg ? -sw_c[CORDIC_N].x : sw_c[CORDIC_N].x;
      n_side_q.ss  <= sw_c[CORDIC_N].neg ? -sw_c[CORDIC_N].y : sw_c[CORDIC_N].y;
      n_side_q.ca  <= ab_c[CORDIC_N].neg ? -ab_c[CORDIC_N].x : ab_c[CORDIC_N].x;
      n_side_q.sa  <= ab_c[CORDIC_N].neg ? -ab_c[CORDIC_N].y : ab_c[CORDIC_N].y;
      n_side_q.leg <= leg_c_q[CORDIC_N];
    end
  end

  // Squared leg length: u^2 + l^2 + round(2 u l cos(knee)), clamped at zero.
  logic signed [CW-1:0]     k1_ck_q;
  logic [UV_W-1:0]          k1_uv_q;
  logic [SQS_W-1:0]         k1_sq_q, k2_sq_q;
  logic signed [PROD_W-1:0] k2_prod_q;
  sqrt_t                    k3_q;
  side_t                    side_q [KS_DLY];
  logic signed [PROD_W:0]   k3_t, k3_l2;

  always_comb begin
    k3_t  = ((PROD_W+1)'(k2_prod_q) <<< 1) + ((PROD_W+1)'(1) <<< (RND_SH-1));
    k3_l2 = (PROD_W+1)'($signed({1'b0, k2_sq_q})) + (k3_t >>> RND_SH);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k1_ck_q   <= n_ck_q;
      k1_uv_q   <= UV_W'(upper_len_q) * UV_W'(lower_len_q);
      k1_sq_q   <= SQS_W'(upper_len_q) * SQS_W'(upper_len_q)
                 + SQS_W'(lower_len_q) * SQS_W'(lower_len_q);
      k2_prod_q <= PROD_W'($signed({1'b0, k1_uv_q})) * PROD_W'(k1_ck_q);
      k2_sq_q   <= k1_sq_q;
      k3_q.rem  <= '0;
      k3_q.root <= '0;
      if (k3_l2 < 0) begin
        k3_q.n <= '0;
      end else begin
        k3_q.n <= SQ_IN_W'({k3_l2[L2_W-1:0], {SQ_PRE_SH{1'b0}}});
      end
      side_q[0] <= n_side_q;
      for (int i = 0; i < KS_DLY - 1; i++) begin
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // Square-root chain, one root bit per cell.
  sqrt_t sq_c [SQ_N+1];

  assign sq_c[0] = k3_q;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    lfk_sqrt_cell u_sq (
      .clk_i(clk_i),
      .en_i (adv),
      .sq_i (sq_c[i]),
      .sq_o (sq_c[i+1])
    );
  end

  // Hip frame point, abduction rotation, rounding.
  logic signed [MUL1_W-1:0] p1_prs_q, p1_prc_q;
  side_t                    p1_side_q, p2_side_q;
  logic signed [MUL1_W:0]   p2_xt, p2_zt;
  logic signed [XH_W-1:0]   p2_xh_q, p2_zh_q, p3_xh_q;
  logic signed [YH_W-1:0]   p2_yh_q, p2_ymag;
  logic signed [M2_W-1:0]   p3_m1_q, p3_m2_q, p3_m3_q, p3_m4_q;
  logic [LEG_W-1:0]         p3_leg_q, p4_leg_q;
  logic signed [M2_W:0]     p4_ys, p4_zs;
  logic signed [XH_W-1:0]   p4_xs;
  logic signed [PT_W-1:0]   p4_px_q, p4_py_q, p4_pz_q;

  always_comb begin
    p2_xt   = ((MUL1_W+1)'(1) <<< (RND_SH-1)) - (MUL1_W+1)'(p1_prs_q);
    p2_zt   = ((MUL1_W+1)'(1) <<< (RND_SH-1)) - (MUL1_W+1)'(p1_prc_q);
    p2_ymag = YH_W'({hip_len_q, {X_SH{1'b0}}});
    p4_ys   = (M2_W+1)'(p3_m1_q) - (M2_W+1)'(p3_m2_q) + ((M2_W+1)'(1) <<< (OUT_SH-1));
    p4_zs   = (M2_W+1)'(p3_m3_q) + (M2_W+1)'(p3_m4_q) + ((M2_W+1)'(1) <<< (OUT_SH-1));
    p4_xs   = p3_xh_q + (XH_W'(1) <<< (X_SH-1));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_prs_q  <= MUL1_W'($signed({1'b0, sq_c[SQ_N].root})) * MUL1_W'(side_q[KS_DLY-1].ss);
      p1_prc_q  <= MUL1_W'($signed({1'b0, sq_c[SQ_N].root})) * MUL1_W'(side_q[KS_DLY-1].cs);
      p1_side_q <= side_q[KS_DLY-1];
      p2_xh_q   <= XH_W'(p2_xt >>> RND_SH);
      p2_zh_q   <= XH_W'(p2_zt >>> RND_SH);
      p2_yh_q   <= p1_side_q.leg[0] ? p2_ymag : -p2_ymag;
      p2_side_q <= p1_side_q;
      p3_m1_q   <= M2_W'(p2_side_q.ca) * M2_W'(p2_yh_q);
      p3_m2_q   <= M2_W'(p2_side_q.sa) * M2_W'(p2_zh_q);
      p3_m3_q   <= M2_W'(p2_side_q.sa) * M2_W'(p2_yh_q);
      p3_m4_q   <= M2_W'(p2_side_q.ca) * M2_W'(p2_zh_q);
      p3_xh_q   <= p2_xh_q;
      p3_leg_q  <= p2_side_q.leg;
      p4_px_q   <= PT_W'(p4_xs >>> X_SH);
      p4_py_q   <= PT_W'(p4_ys >>> OUT_SH);
      p4_pz_q   <= PT_W'(p4_zs >>> OUT_SH);
      p4_leg_q  <= p3_leg_q;
    end
  end

  // Hip offset of the leg, then saturation to the output range.
  logic [OFS_W-1:0]     ofs_sel;
  logic signed [PT_W:0] sx, sy, sz;
  fk_out_t              out_d;

  always_comb begin
    ofs_sel = '0;
    for (int k = 0; k < NUM_LEGS; k++) begin
      if (p4_leg_q == LEG_W'(k)) begin
        ofs_sel = ofs_q[k];
      end
    end
    sx = (PT_W+1)'(p4_px_q) + (PT_W+1)'($signed(ofs_sel[POS_W-1:0]));
    sy = (PT_W+1)'(p4_py_q) + (PT_W+1)'($signed(ofs_sel[2*POS_W-1:POS_W]));
    sz = (PT_W+1)'(p4_pz_q) + (PT_W+1)'($signed(ofs_sel[3*POS_W-1:2*POS_W]));
    out_d.saturated = 1'b0;
    priority if (sx > POS_MAX) begin
      out_d.foot_x = POS_W'(POS_MAX); out_d.saturated = 1'b1;
    end else if (sx < POS_MIN) begin
      out_d.foot_x = POS_W'(POS_MIN); out_d.saturated = 1'b1;
    end else begin
      out_d.foot_x = POS_W'(sx);
    end
    priority if (sy > POS_MAX) begin
      out_d.foot_y = POS_W'(POS_MAX); out_d.saturated = 1'b1;
    end else if (sy < POS_MIN) begin
      out_d.foot_y = POS_W'(POS_MIN); out_d.saturated = 1'b1;
    end else begin
      out_d.foot_y = POS_W'(sy);
    end
    priority if (sz > POS_MAX) begin
      out_d.foot_z = POS_W'(POS_MAX); out_d.saturated = 1'b1;
    end else if (sz < POS_MIN) begin
      out_d.foot_z = POS_W'(POS_MIN); out_d.saturated = 1'b1;
    end else begin
      out_d.foot_z = POS_W'(sz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held output freezes every valid bit.
  a_hold_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // Valid bits march one stage per advancing cycle.
  a_valid_march: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld_q[PRE_STG-1:1] == $past(vld_q[PRE_STG-2:0]))
    else $error("valid bits did not shift");

  // A result beat appears only from the last pipeline stage.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[PRE_STG-1]))
    else $error("output beat without a source stage");

endmodule

FILE: bench/leg_forward_kinematics_check.sv
`timescale 1ns / 1ps

module leg_forward_kinematics_check import lfk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  fk_in_t               in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  fk_out_t              out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OFS_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   sat_seen_o
);

  localparam longint PI_A   = 64'sd52707179;
  localparam longint HPI_A  = 64'sd26353589;
  localparam longint TPI_A  = 64'sd105414357;
  localparam longint GAIN_K = 64'sd652032874;

  // Shadow copy of the configuration registers.
  longint unsigned  hip_len, upper_len, lower_len;
  longint unsigned  leg_ofs [NUM_LEGS];
  fk_out_t          foot_queue [$];

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sext16(longint unsigned v);
    return longint'(signed'(v[15:0]));
  endfunction

  // Rotation CORDIC on an angle in 2^-24 rad; cosine and sine in Q2.30.
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    longint atan_v;
    bit     flip;
    x = GAIN_K;
    y = 0;
    flip = 0;
    while (ang > PI_A) ang -= TPI_A;
    while (ang < -PI_A) ang += TPI_A;
    if (ang > HPI_A) begin
      ang -= PI_A;
      flip = 1;
    end else if (ang < -HPI_A) begin
      ang += PI_A;
      flip = 1;
    end
    z = ang;
    for (int i = 0; i < CORDIC_N; i++) begin
      atan_v = longint'(atan_at(i[SH_W-1:0]));
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y  = y + shr_floor(x, i);
        z -= atan_v;
      end else begin
        nx = x + shr_floor(y, i);
        y  = y - shr_floor(x, i);
        z += atan_v;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip16(longint v, inout bit hit);
    if (v > 32767) begin
      hit = 1;
      return 32767;
    end
    if (v < -32768) begin
      hit = 1;
      return -32768;
    end
    return v;
  endfunction

  // Foot position for one leg beat under the current register values.
  task automatic foot_position(input fk_in_t a, output fk_out_t r);
    longint ab, hp, kn, u, l, ck, sk, cs, ss, ca, sa, l2, lf;
    longint xh, yh, zh, px, py, pz, ox, oy, oz;
    bit     hit;
    ab = longint'(a.abduction_angle);
    hp = longint'(a.hip_angle);
    kn = longint'(a.knee_angle);
    u  = longint'(upper_len);
    l  = longint'(lower_len);
    hit = 0;
    cordic_sincos(kn * 2048, ck, sk);
    l2 = u * u + l * l + round_half_up(2 * u * l * ck, 30);
    if (l2 < 0) l2 = 0;
    lf = longint'(int_sqrt(longint'(l2) << 16));
    cordic_sincos((2 * hp + kn) * 1024, cs, ss);
    xh = round_half_up(-lf * ss, 30);
    zh = round_half_up(-lf * cs, 30);
    yh = longint'(hip_len) * 256;
    if (!a.leg[0]) yh = -yh;
    cordic_sincos(ab * 2048, ca, sa);
    px = round_half_up(xh, 8);
    py = round_half_up(ca * yh - sa * zh, 38);
    pz = round_half_up(sa * yh + ca * zh, 38);
    ox = 0;
    oy = 0;
    oz = 0;
    if (int'(a.leg) < NUM_LEGS) begin
      ox = sext16(leg_ofs[a.leg]);
      oy = sext16(leg_ofs[a.leg] >> 16);
      oz = sext16(leg_ofs[a.leg] >> 32);
    end
    r.foot_x    = 16'(clip16(px + ox, hit));
    r.foot_y    = 16'(clip16(py + oy, hit));
    r.foot_z    = 16'(clip16(pz + oz, hit));
    r.saturated = hit;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    sat_seen_o   = 0;
  end

  assign pending_o = foot_queue.size();

  // Track register writes, predict accepted beats, and compare result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    fk_out_t want;
    if (!rst_ni) begin
      hip_len   = 0;
      upper_len = 0;
      lower_len = 0;
      foreach (leg_ofs[k]) leg_ofs[k] = 0;
      foot_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (foot_queue.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = foot_queue.pop_front();
          checked_o++;
          if (out_data_i.saturated) sat_seen_o++;
          if (out_data_i.foot_x !== want.foot_x)
            report_mismatch("foot_x", out_data_i.foot_x, want.foot_x);
          if (out_data_i.foot_y !== want.foot_y)
            report_mismatch("foot_y", out_data_i.foot_y, want.foot_y);
          if (out_data_i.foot_z !== want.foot_z)
            report_mismatch("foot_z", out_data_i.foot_z, want.foot_z);
          if (out_data_i.saturated !== want.saturated)
            report_mismatch("saturated", out_data_i.saturated, want.saturated);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        foot_position(in_data_i, want);
        foot_queue.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_HIP) hip_len = cfg_data_i[LEN_W-1:0];
        else if (cfg_index_i == REG_UPPER) upper_len = cfg_data_i[LEN_W-1:0];
        else if (cfg_index_i == REG_LOWER) lower_len = cfg_data_i[LEN_W-1:0];
        else if (cfg_index_i >= REG_OFS_BASE && cfg_index_i < REG_OFS_BASE + NUM_LEGS)
          leg_ofs[cfg_index_i - REG_OFS_BASE] = cfg_data_i;
      end
    end
  end

endmodule

FILE: bench/leg_forward_kinematics_test.sv
`timescale 1ns / 1ps

module leg_forward_kinematics_test import lfk_pkg::*;;

  localparam int RAND_BEATS = 1200;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 80;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sd25736;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  fk_in_t               in_data;
  logic                 out_valid;
  logic                 out_stall;
  fk_out_t              out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OFS_W-1:0]     cfg_data;
  int                   fail_count, pending, checked, sat_seen;
  int                   idle_cycles;
  int                   phases;

  leg_forward_kinematics i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  leg_forward_kinematics_check i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .sat_seen_o  (sat_seen)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stall pattern: quiet stretches, light stalls, heavy stalls.
  initial begin
    int mode, span;
    out_stall = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(posedge clk_i);
        unique case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no accepted beat on any channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** leg_forward_kinematics: FAILED **");
        $finish;
      end
    end
  end

  // Valid stays high between chained writes; the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Drive one leg beat; valid stays high into the next beat when chained.
  task automatic send_leg(input fk_in_t beat, input bit keep);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
    if (!keep) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Program every register for one phase; extreme selects the corner values.
  task automatic load_config(input int extreme);
    logic [OFS_W-1:0] ofs;
    write_reg(REG_HIP,   extreme == 1 ? 48'h3FFF : extreme == 2 ? 48'h0 : $urandom_range(0, 2000));
    write_reg(REG_UPPER, extreme == 1 ? 48'h3FFF : extreme == 2 ? 48'h0 : $urandom_range(500, 4000));
    write_reg(REG_LOWER, extreme == 1 ? 48'h3FFF : extreme == 2 ? 48'h0 : $urandom_range(500, 4000));
    for (int k = 0; k < NUM_LEGS; k++) begin
      if (extreme == 1)
        ofs = (k[0]) ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000;
      else if (extreme == 2)
        ofs = 48'hFFFF_FFFF_FFFF;
      else
        ofs = {16'($urandom_range(0, 6000) - 3000), 16'($urandom_range(0, 6000) - 3000),
               16'($urandom_range(0, 6000) - 3000)};
      write_reg(CFG_IDX_W'(REG_OFS_BASE + k), ofs);
    end
    // Index past the last register must be ignored.
    write_reg(CFG_IDX_W'(REG_OFS_BASE + NUM_LEGS), 48'hFFFF_FFFF_FFFF);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return ANG_W'($urandom);
    return ANG_W'($urandom_range(0, 2 * 25736) - 25736);
  endfunction

  // Random beats sent in bursts separated by random gaps.
  task automatic random_phase(input int count);
    fk_in_t beat;
    int     burst;
    int     gap;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > count) burst = count;
      gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 15) : 0;
      // With no gap the next burst follows directly, so valid stays high.
      for (int b = 0; b < burst; b++) begin
        beat.leg             = LEG_W'($urandom_range(0, 3));
        beat.abduction_angle = rand_angle();
        beat.hip_angle       = rand_angle();
        beat.knee_angle      = rand_angle();
        send_leg(beat, (b != burst - 1) || (gap == 0 && count > burst));
      end
      count -= burst;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    fk_in_t beat;
    logic signed [ANG_W-1:0] corner [6];
    rst_ni    = 0;
    in_valid  = 0;
    in_data   = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data  = '0;
    corner    = '{16'sh0000, ANG_MAX, -ANG_MAX, 16'sh7FFF, 16'sh8000, 16'sh3244};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all legs with reset registers, then corner angles at the largest lengths.
    for (int k = 0; k < 4; k++) begin
      beat = '{leg: LEG_W'(k), abduction_angle: corner[k], hip_angle: corner[k + 1],
               knee_angle: corner[k + 2]};
      send_leg(beat, k != 3);
    end
    wait_drained();
    load_config(1);
    for (int k = 0; k < 18; k++) begin
      beat = '{leg: LEG_W'(k), abduction_angle: corner[k % 6], hip_angle: corner[(k / 6) * 2],
               knee_angle: corner[(k + 3) % 6]};
      send_leg(beat, k != 17);
    end

    // Hold off until the pipeline empties, then run several settings.
    wait_drained();
    load_config(2);
    random_phase(150);
    wait_drained();
    phases = 2;
    for (int p = 0; p < 5; p++) begin
      load_config(0);
      random_phase((RAND_BEATS - 150) / 5);
      wait_drained();
      phases++;
    end

    $display("Checked %0d foot positions over %0d register settings, %0d saturated.",
             checked, phases + 1, sat_seen);
    if (fail_count == 0) begin
      $display("** leg_forward_kinematics: PASSED **");
    end else begin
      $display("** leg_forward_kinematics: FAILED **");
    end
    $finish;
  end

endmodule
